/* sv/sbus_frame_decoder_macros.svh */
// assertion helpers, clock and reset of the including module are used
`ifndef SBUS_FRAME_DECODER_MACROS_SVH
`define SBUS_FRAME_DECODER_MACROS_SVH

// same-cycle implication
`define SFD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SFD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/sfd_pkg.sv */
`timescale 1ns / 1ps

package sfd_pkg;

   localparam int FRAME_BYTES_DEF   = 24;
   localparam int CHANNEL_COUNT_DEF = 16;
   localparam int CHANNEL_BITS      = 11;
   localparam int STORE_BYTES       = 22;
   localparam int BYTE_W            = 8;
   localparam int FRAME_W           = STORE_BYTES * BYTE_W;
   localparam int INDEX_W           = 4;
   localparam int PULSE_W           = 13;
   localparam int BASE_W            = 12;
   localparam int GAIN_W            = 16;
   localparam int FRAC_W            = 16;
   localparam int PROD_W            = CHANNEL_BITS + GAIN_W;
   localparam int CSR_W             = 16;
   localparam int CSR_INDEX_W       = 2;
   localparam int QUEUE_DEPTH       = 2;

   localparam logic [BYTE_W-1:0]       SYNC_RST   = 8'h0F;
   localparam logic [CHANNEL_BITS-1:0] OFFSET_RST = 11'd352;
   localparam logic [BASE_W-1:0]       BASE_RST   = 12'd1000;
   localparam logic [GAIN_W-1:0]       GAIN_RST   = 16'd48761;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SYNC_BYTE,
      CSR_SCALE_OFFSET,
      CSR_SCALE_BASE,
      CSR_SCALE_GAIN
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0]       sync_byte;
      logic [CHANNEL_BITS-1:0] scale_offset;
      logic [BASE_W-1:0]       scale_base;
      logic [GAIN_W-1:0]       scale_gain;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef logic [FRAME_W-1:0] frame_type;

endpackage

/* sv/sfd_if.sv */
`timescale 1ns / 1ps

interface sfd_req_if;
   logic                        valid;
   logic                        ready;
   logic [sfd_pkg::BYTE_W-1:0]  rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [sfd_pkg::INDEX_W-1:0]       channel_index;
   logic [sfd_pkg::CHANNEL_BITS-1:0]  raw_value;
   logic [sfd_pkg::PULSE_W-1:0]       pulse_us;
   logic                              last_channel;

   modport source (output valid, output channel_index, output raw_value,
                   output pulse_us, output last_channel, input ready);
   modport sink (input valid, input channel_index, input raw_value,
                 input pulse_us, input last_channel, output ready);
endinterface

/* sv/sfd_front.sv */
`timescale 1ns / 1ps
`include "sbus_frame_decoder_macros.svh"

module sfd_front #(
   parameter int FRAME_BYTES = sfd_pkg::FRAME_BYTES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   sfd_req_if.sink                    req,
   input  logic [sfd_pkg::BYTE_W-1:0] sync_byte,
   input  sfd_pkg::queue_stat_type    q_stat,
   output logic                       push,
   output sfd_pkg::frame_type         push_data
);

   localparam int CNT_W = $clog2(FRAME_BYTES + 1);
   localparam int IDX_W = $clog2(sfd_pkg::STORE_BYTES);

   logic                       in_frame_ff, in_frame_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [sfd_pkg::BYTE_W-1:0] store_ff [sfd_pkg::STORE_BYTES];
   logic                       accept;
   logic                       frame_end;
   logic                       store_we;
   logic [IDX_W-1:0]           store_idx;

   always_comb begin
      accept      = req.valid && req.ready;
      frame_end   = in_frame_ff && (count_ff == CNT_W'(FRAME_BYTES));
      in_frame_in = in_frame_ff;
      count_in    = count_ff;
      if (accept) begin
         if (!in_frame_ff) begin
            if (req.rx_byte == sync_byte) begin
               in_frame_in = 1'b1;
               count_in    = CNT_W'(1);
            end
         end else if (frame_end) begin
            in_frame_in = 1'b0;
            count_in    = CNT_W'(1);
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   assign req.ready = !(frame_end && q_stat.full);
   assign push      = accept && frame_end;
   assign store_we  = accept && in_frame_ff && (count_ff <= CNT_W'(sfd_pkg::STORE_BYTES));
   assign store_idx = IDX_W'(count_ff - CNT_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         count_ff    <= CNT_W'(1);
      end else begin
         in_frame_ff <= in_frame_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[store_idx] <= req.rx_byte;
      end
   end

   // bytes laid out lsb first, channel bits follow in order
   always_comb begin
      for (int i = 0; i < sfd_pkg::STORE_BYTES; i++) begin
         push_data[i*sfd_pkg::BYTE_W +: sfd_pkg::BYTE_W] = store_ff[i];
      end
   end

   `SFD_ASSERT_SAME(a_count_range, in_frame_ff,
      (count_ff >= CNT_W'(1)) && (count_ff <= CNT_W'(FRAME_BYTES)), "byte count out of range")
   `SFD_ASSERT_SAME(a_push_room, push, !q_stat.full, "frame pushed into full queue")

endmodule

/* sv/sfd_queue.sv */
`timescale 1ns / 1ps

module sfd_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  sfd_pkg::frame_type      push_data,
   input  logic                    pop,
   output sfd_pkg::frame_type      pop_data,
   output sfd_pkg::queue_stat_type stat
);

   localparam int PTR_W = $clog2(sfd_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(sfd_pkg::QUEUE_DEPTH + 1);

   sfd_pkg::frame_type mem_ff [sfd_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(sfd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(sfd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data   = mem_ff[rd_ptr_ff];
   assign stat.full  = (fill_ff == CNT_W'(sfd_pkg::QUEUE_DEPTH));
   assign stat.empty = (fill_ff == '0);

endmodule

/* sv/sfd_back.sv */
`timescale 1ns / 1ps
`include "sbus_frame_decoder_macros.svh"

module sfd_back #(
   parameter int CHANNEL_COUNT = sfd_pkg::CHANNEL_COUNT_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sfd_pkg::cfg_type        cfg,
   input  sfd_pkg::queue_stat_type q_stat,
   output logic                    pop,
   input  sfd_pkg::frame_type      pop_data,
   sfd_rsp_if.source               rsp
);

   localparam int IW = sfd_pkg::INDEX_W;
   localparam int RW = sfd_pkg::CHANNEL_BITS;
   localparam int PW = sfd_pkg::PROD_W;
   localparam int OW = sfd_pkg::PULSE_W;

   logic               busy_ff, busy_in;
   logic [IW-1:0]      ch_ff, ch_in;
   sfd_pkg::frame_type data_ff, data_in;

   logic               s1_v_ff;
   logic [IW-1:0]      s1_idx_ff;
   logic [RW-1:0]      s1_raw_ff;
   logic               s1_last_ff;
   logic               s1_gt_ff;
   logic [PW-1:0]      s1_prod_ff;

   logic               out_v_ff;
   logic [IW-1:0]      out_idx_ff;
   logic [RW-1:0]      out_raw_ff;
   logic [OW-1:0]      out_pulse_ff, out_pulse_in;
   logic               out_last_ff;

   logic               adv;
   logic               issue;
   logic               ch_last;
   logic [RW-1:0]      raw_now;
   logic [RW-1:0]      diff_now;
   logic               gt_now;
   logic [PW-1:0]      prod_now;

   assign adv     = !out_v_ff || rsp.ready;
   assign issue   = busy_ff && adv;
   assign pop     = !busy_ff && !q_stat.empty;
   assign ch_last = (ch_ff == IW'(CHANNEL_COUNT - 1));
   assign raw_now  = data_ff[RW-1:0];
   assign gt_now   = raw_now > cfg.scale_offset;
   assign diff_now = raw_now - cfg.scale_offset;
   assign prod_now = PW'(diff_now) * PW'(cfg.scale_gain);

   always_comb begin
      busy_in = busy_ff;
      ch_in   = ch_ff;
      data_in = data_ff;
      if (pop) begin
         busy_in = 1'b1;
         ch_in   = '0;
         data_in = pop_data;
      end else if (issue) begin
         ch_in   = ch_ff + IW'(1);
         data_in = data_ff >> RW;
         if (ch_last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_comb begin
      out_pulse_in = OW'(cfg.scale_base);
      if (s1_gt_ff) begin
         out_pulse_in = OW'(cfg.scale_base) + OW'(s1_prod_ff[PW-1:sfd_pkg::FRAC_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         ch_ff    <= '0;
         s1_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         ch_ff   <= ch_in;
         if (adv) begin
            s1_v_ff  <= issue;
            out_v_ff <= s1_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (adv) begin
         s1_idx_ff    <= ch_ff;
         s1_raw_ff    <= raw_now;
         s1_last_ff   <= ch_last;
         s1_gt_ff     <= gt_now;
         s1_prod_ff   <= prod_now;
         out_idx_ff   <= s1_idx_ff;
         out_raw_ff   <= s1_raw_ff;
         out_pulse_ff <= out_pulse_in;
         out_last_ff  <= s1_last_ff;
      end
   end

   assign rsp.valid         = out_v_ff;
   assign rsp.channel_index = out_idx_ff;
   assign rsp.raw_value     = out_raw_ff;
   assign rsp.pulse_us      = out_pulse_ff;
   assign rsp.last_channel  = out_last_ff;

   `SFD_ASSERT_NEXT(a_last_frees, issue && ch_last, !busy_ff, "busy after last channel")
   `SFD_ASSERT_NEXT(a_stall_holds, s1_v_ff && !adv, s1_v_ff && $stable(s1_raw_ff),
      "stage one lost during stall")
   `SFD_ASSERT_SAME(a_last_tag, out_v_ff && out_last_ff,
      out_idx_ff == IW'(CHANNEL_COUNT - 1), "last flag on wrong channel")

endmodule

/* sv/sbus_frame_decoder.sv */
// sbus frame decoder
// req_ch carries one received byte per transaction (valid/ready). while idle
// the block waits for a byte equal to sync_byte, then takes the next
// FRAME_BYTES body bytes and keeps the first 22. the sync value inside a
// frame is ordinary data; non-sync bytes while idle are dropped.
// after the last body byte the frame moves into a two-frame queue and the
// back end emits CHANNEL_COUNT transactions on rsp_ch, one per channel,
// channel 0 first, last_channel set on the final one.
// after the last body byte is taken, the frame goes through the queue, the
// back end's frame register, stage one and the output register; results then
// come one per cycle while rsp_ch.ready is high. req_ch takes one byte per
// cycle sustained; the back end loads a frame, then one channel per cycle.
// when rsp_ch stalls the back end holds; bytes keep flowing until the
// queue is full, and then req_ch.ready drops only on a frame's last byte.
// csr_we/csr_index/csr_wdata write sync_byte, scale_offset, scale_base,
// scale_gain; write only while no frame is in flight.
// synchronous reset clears the frame state and queue and loads the
// register defaults: 0x0f, 352, 1000, 48761.
`timescale 1ns / 1ps

module sbus_frame_decoder #(
   parameter int FRAME_BYTES   = sfd_pkg::FRAME_BYTES_DEF,
   parameter int CHANNEL_COUNT = sfd_pkg::CHANNEL_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   sfd_req_if.sink                         req_ch,
   sfd_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [sfd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sfd_pkg::CSR_W-1:0]       csr_wdata
);

   sfd_pkg::cfg_type        cfg_ff, cfg_in;
   sfd_pkg::queue_stat_type q_stat;
   sfd_pkg::frame_type      push_data;
   sfd_pkg::frame_type      pop_data;
   logic                    push;
   logic                    pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (sfd_pkg::csr_index_type'(csr_index))
            sfd_pkg::CSR_SYNC_BYTE:    cfg_in.sync_byte    = csr_wdata[sfd_pkg::BYTE_W-1:0];
            sfd_pkg::CSR_SCALE_OFFSET: cfg_in.scale_offset =
               csr_wdata[sfd_pkg::CHANNEL_BITS-1:0];
            sfd_pkg::CSR_SCALE_BASE:   cfg_in.scale_base   = csr_wdata[sfd_pkg::BASE_W-1:0];
            sfd_pkg::CSR_SCALE_GAIN:   cfg_in.scale_gain   = csr_wdata[sfd_pkg::GAIN_W-1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_byte    <= sfd_pkg::SYNC_RST;
         cfg_ff.scale_offset <= sfd_pkg::OFFSET_RST;
         cfg_ff.scale_base   <= sfd_pkg::BASE_RST;
         cfg_ff.scale_gain   <= sfd_pkg::GAIN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sfd_front #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .sync_byte (cfg_ff.sync_byte),
      .q_stat    (q_stat),
      .push      (push),
      .push_data (push_data)
   );

   sfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .stat      (q_stat)
   );

   sfd_back #(
      .CHANNEL_COUNT (CHANNEL_COUNT)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_stat   (q_stat),
      .pop      (pop),
      .pop_data (pop_data),
      .rsp      (rsp_ch)
   );

endmodule

/* bench/sbus_frame_decoder_test.sv */
`timescale 1ns / 1ps

module sbus_frame_decoder_test;

   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_WAIT    = 9;

   typedef struct {
      logic [sfd_pkg::INDEX_W-1:0]      index;
      logic [sfd_pkg::CHANNEL_BITS-1:0] raw;
      logic [sfd_pkg::PULSE_W-1:0]      pulse;
      logic                             last;
   } channel_result_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   sfd_pkg::csr_index_type csr_index;
   logic [sfd_pkg::CSR_W-1:0] csr_wdata;

   sfd_req_if req_if ();
   sfd_rsp_if rsp_if ();

   sbus_frame_decoder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // decoder shadow state
   sfd_pkg::cfg_type shadow_cfg = '{sfd_pkg::SYNC_RST, sfd_pkg::OFFSET_RST,
                                    sfd_pkg::BASE_RST, sfd_pkg::GAIN_RST};
   bit in_frame = 1'b0;
   int body_count = 1;
   logic [sfd_pkg::BYTE_W-1:0] frame_bytes [sfd_pkg::STORE_BYTES];

   channel_result_type expected_channels [$];
   logic [sfd_pkg::BYTE_W-1:0] pending_bytes [$];

   bit pace_on = 1'b0;
   bit req_busy = 1'b0;
   bit byte_taken = 1'b0;
   bit result_taken = 1'b0;
   int send_gap = 0;
   int rsp_stall = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   function automatic int draw_wait();
      return pace_on ? int'($urandom_range(0, MAX_WAIT)) : 0;
   endfunction

   function automatic void decode_byte(input logic [sfd_pkg::BYTE_W-1:0] rx);
      sfd_pkg::frame_type bits;
      channel_result_type entry;
      logic [sfd_pkg::PROD_W-1:0] product;
      if (!in_frame) begin
         if (rx == shadow_cfg.sync_byte) begin
            in_frame = 1'b1;
            body_count = 1;
         end
         return;
      end
      if (body_count <= sfd_pkg::STORE_BYTES)
         frame_bytes[body_count-1] = rx;
      if (body_count < sfd_pkg::FRAME_BYTES_DEF) begin
         body_count++;
         return;
      end
      in_frame = 1'b0;
      body_count = 1;
      for (int i = 0; i < sfd_pkg::STORE_BYTES; i++)
         bits[i*sfd_pkg::BYTE_W +: sfd_pkg::BYTE_W] = frame_bytes[i];
      for (int k = 0; k < sfd_pkg::CHANNEL_COUNT_DEF; k++) begin
         entry.index = k[sfd_pkg::INDEX_W-1:0];
         entry.raw = bits[k*sfd_pkg::CHANNEL_BITS +: sfd_pkg::CHANNEL_BITS];
         entry.pulse = sfd_pkg::PULSE_W'(shadow_cfg.scale_base);
         if (entry.raw > shadow_cfg.scale_offset) begin
            product = sfd_pkg::PROD_W'(entry.raw - shadow_cfg.scale_offset)
                      * sfd_pkg::PROD_W'(shadow_cfg.scale_gain);
            entry.pulse = sfd_pkg::PULSE_W'(shadow_cfg.scale_base)
                          + sfd_pkg::PULSE_W'(product[sfd_pkg::PROD_W-1:sfd_pkg::FRAC_W]);
         end
         entry.last = (k == sfd_pkg::CHANNEL_COUNT_DEF - 1);
         expected_channels.push_back(entry);
      end
   endfunction

   // prediction on accepted bytes, checking of accepted channel results
   always @(posedge clock) begin : monitor
      channel_result_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            decode_byte(req_if.rx_byte);
            byte_taken = 1'b1;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            result_taken = 1'b1;
            if (expected_channels.size() == 0) begin
               report_mismatch($sformatf("unexpected result for channel %0d",
                                         rsp_if.channel_index));
            end else begin
               want = expected_channels.pop_front();
               if (rsp_if.channel_index !== want.index)
                  report_mismatch($sformatf("channel_index %0d, wanted %0d",
                                            rsp_if.channel_index, want.index));
               if (rsp_if.raw_value !== want.raw)
                  report_mismatch($sformatf("channel %0d raw_value %0d, wanted %0d",
                                            want.index, rsp_if.raw_value, want.raw));
               if (rsp_if.pulse_us !== want.pulse)
                  report_mismatch($sformatf("channel %0d pulse_us %0d, wanted %0d",
                                            want.index, rsp_if.pulse_us, want.pulse));
               if (rsp_if.last_channel !== want.last)
                  report_mismatch($sformatf("channel %0d last_channel %0b, wanted %0b",
                                            want.index, rsp_if.last_channel, want.last));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", expected_channels.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // byte driver
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.rx_byte <= '0;
      end else begin
         if (byte_taken) begin
            byte_taken = 1'b0;
            req_busy = 1'b0;
            send_gap = draw_wait();
         end
         if (!req_busy) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_bytes.size() > 0) begin
               req_if.rx_byte <= pending_bytes.pop_front();
               req_busy = 1'b1;
            end
         end
         req_if.valid <= req_busy;
      end
   end

   // result receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (result_taken) begin
            result_taken = 1'b0;
            rsp_stall = draw_wait();
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   task automatic write_register(input sfd_pkg::csr_index_type index,
                                 input logic [sfd_pkg::CSR_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         sfd_pkg::CSR_SYNC_BYTE:
            shadow_cfg.sync_byte = value[sfd_pkg::BYTE_W-1:0];
         sfd_pkg::CSR_SCALE_OFFSET:
            shadow_cfg.scale_offset = value[sfd_pkg::CHANNEL_BITS-1:0];
         sfd_pkg::CSR_SCALE_BASE:
            shadow_cfg.scale_base = value[sfd_pkg::BASE_W-1:0];
         sfd_pkg::CSR_SCALE_GAIN:
            shadow_cfg.scale_gain = value[sfd_pkg::GAIN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic write_settings(input logic [sfd_pkg::CSR_W-1:0] sync_value,
                                 input logic [sfd_pkg::CSR_W-1:0] offset,
                                 input logic [sfd_pkg::CSR_W-1:0] base,
                                 input logic [sfd_pkg::CSR_W-1:0] gain);
      write_register(sfd_pkg::CSR_SYNC_BYTE, sync_value);
      write_register(sfd_pkg::CSR_SCALE_OFFSET, offset);
      write_register(sfd_pkg::CSR_SCALE_BASE, base);
      write_register(sfd_pkg::CSR_SCALE_GAIN, gain);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // finish any open frame and wait for every channel result
   task automatic settle_decoder();
      do begin
         while (pending_bytes.size() > 0 || req_busy)
            @(negedge clock);
         if (in_frame)
            repeat (sfd_pkg::FRAME_BYTES_DEF - body_count + 1)
               pending_bytes.push_back(sfd_pkg::BYTE_W'($urandom_range(0, 255)));
      end while (pending_bytes.size() > 0);
      while (expected_channels.size() > 0)
         @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic push_frame_traffic(input int frames);
      logic [sfd_pkg::BYTE_W-1:0] b;
      int body_len;
      repeat (frames) begin
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
               do b = sfd_pkg::BYTE_W'($urandom_range(0, 255));
               while (b == shadow_cfg.sync_byte);
               pending_bytes.push_back(b);
            end
         end
         pending_bytes.push_back(shadow_cfg.sync_byte);
         body_len = ($urandom_range(0, 7) == 0)
                    ? $urandom_range(1, sfd_pkg::FRAME_BYTES_DEF - 1)
                    : sfd_pkg::FRAME_BYTES_DEF;
         repeat (body_len) begin
            if ($urandom_range(0, 15) == 0)
               pending_bytes.push_back(shadow_cfg.sync_byte);
            else
               pending_bytes.push_back(sfd_pkg::BYTE_W'($urandom_range(0, 255)));
         end
         pace_on = ($urandom_range(0, 2) != 0);
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = sfd_pkg::CSR_SYNC_BYTE;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.rx_byte = '0;
      rsp_if.ready = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // idle noise, then a frame with max and zero channels, one at the offset,
      // the sync value as data and ignored trailing bytes
      pending_bytes.push_back(8'h00);
      pending_bytes.push_back(8'hFF);
      pending_bytes.push_back(shadow_cfg.sync_byte);
      repeat (11) pending_bytes.push_back(8'hFF);
      pending_bytes.push_back(8'h60);
      pending_bytes.push_back(8'h01);
      pending_bytes.push_back(shadow_cfg.sync_byte);
      repeat (8) pending_bytes.push_back(8'h00);
      pending_bytes.push_back(8'hFF);
      pending_bytes.push_back(shadow_cfg.sync_byte);
      settle_decoder();

      pace_on = 1'b1;
      push_frame_traffic(1);
      settle_decoder();

      // low extremes, upper write bits set where the register is narrower
      write_settings(16'hFF00, 16'hF800, 16'hF000, 16'h0000);
      push_frame_traffic(1);
      settle_decoder();

      // high extremes: nothing is above the offset
      write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_frame_traffic(1);
      settle_decoder();

      // widest pulse
      write_settings(sfd_pkg::CSR_W'($urandom), 16'h0000, 16'h0FFF, 16'hFFFF);
      pending_bytes.push_back(shadow_cfg.sync_byte);
      repeat (sfd_pkg::FRAME_BYTES_DEF) pending_bytes.push_back(8'hFF);
      settle_decoder();

      write_settings(sfd_pkg::CSR_W'($urandom), sfd_pkg::CSR_W'($urandom),
                     sfd_pkg::CSR_W'($urandom), sfd_pkg::CSR_W'($urandom));
      push_frame_traffic(1);
      settle_decoder();

      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+sv
sv/sfd_pkg.sv
sv/sfd_if.sv
sv/sfd_front.sv
sv/sfd_queue.sv
sv/sfd_back.sv
sv/sbus_frame_decoder.sv
bench/sbus_frame_decoder_test.sv
